// ----- hw/rtl/ksel_pkg.sv -----
// Shared types and constants for the k-th smallest select unit.
package ksel_pkg;

    // Width of the rank register.
    localparam int RANK_W = 5;

    // Rank value at reset.
    localparam logic [RANK_W-1:0] RANK_RESET = RANK_W'(1);

    // Control handed from one cell to the next one up the chain.
    typedef struct packed {
        logic valid;    // cell holds a kept value
        logic shift;    // cell moves its value up on this insert
    } ksel_link_t;

endpackage

// ----- hw/rtl/ksel_cell.sv -----
// One compare-and-shift cell of the sorted insertion chain.
module ksel_cell #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          clear,
    input  logic                          ins_en,
    input  logic signed [VALUE_WIDTH-1:0] ins_value,
    input  ksel_pkg::ksel_link_t          prev_link,
    input  logic signed [VALUE_WIDTH-1:0] prev_value,
    output ksel_pkg::ksel_link_t          link_out,
    output logic signed [VALUE_WIDTH-1:0] value_out
);
    import ksel_pkg::*;

    logic                          valid_reg;
    logic                          valid_next;
    logic signed [VALUE_WIDTH-1:0] value_reg;
    logic signed [VALUE_WIDTH-1:0] value_next;
    logic                          own_shift;

    // Strict less: an equal value lands after the kept copies.
    assign own_shift = valid_reg && (ins_value < value_reg);

    always_comb begin
        valid_next = valid_reg;
        value_next = value_reg;
        if (clear) begin
            valid_next = 1'b0;
        end else if (ins_en) begin
            if (prev_link.shift) begin
                value_next = prev_value;
                valid_next = 1'b1;
            end else if (own_shift) begin
                value_next = ins_value;
            end else if (!valid_reg && prev_link.valid) begin
                value_next = ins_value;
                valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        value_reg <= value_next;
    end

    assign link_out.valid = valid_reg;
    assign link_out.shift = own_shift;
    assign value_out      = value_reg;

endmodule

// ----- hw/rtl/kth_smallest_select_unit.sv -----
// K-th smallest select unit: sorted insertion chain with rank readout.
// Throughput: one word per cycle within a set.
// A word with tlast is inserted, then the chain is read at the rank and cleared;
// s_tready stays low until that readout, which waits while m_ is stalled.
// The result is registered on m_ after pend_reg marks the set as complete.
// Reset (aresetn low, synchronous): chain emptied, no result held, rank = 1.
module kth_smallest_select_unit #(
    parameter int MAX_K       = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [ksel_pkg::RANK_W-1:0]         cfg_wr_data,    // kth_rank
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((VALUE_WIDTH+7)/8)*8-1:0]    s_tdata,        // sample_value
    input  logic                                s_tlast,        // last_item
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [((VALUE_WIDTH+7)/8)*8-1:0]    m_tdata,        // kth_value
    output logic                                m_tuser         // rank_error
);
    import ksel_pkg::*;

    localparam int DATA_W = ((VALUE_WIDTH + 7) / 8) * 8;

    logic [RANK_W-1:0]             rank_reg;
    logic                          pend_reg;
    logic                          m_valid_reg;
    logic signed [VALUE_WIDTH-1:0] m_value_reg;
    logic                          m_error_reg;

    logic                          in_acc;
    logic                          out_free;
    logic                          do_report;
    logic signed [VALUE_WIDTH-1:0] ins_value;

    ksel_link_t                    link   [MAX_K+1];
    logic signed [VALUE_WIDTH-1:0] values [MAX_K+1];

    logic [RANK_W-1:0]             rank_m1;
    logic                          sel_valid;
    logic signed [VALUE_WIDTH-1:0] sel_value;
    logic                          rank_ok;

    assign s_tready  = !pend_reg;
    assign in_acc    = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign do_report = pend_reg && out_free;
    assign ins_value = s_tdata[VALUE_WIDTH-1:0];

    // Head of the chain: always "valid", never shifts.
    assign link[0].valid = 1'b1;
    assign link[0].shift = 1'b0;
    assign values[0]     = '0;

    for (genvar i = 0; i < MAX_K; i++) begin : g_cell
        ksel_cell #(
            .VALUE_WIDTH(VALUE_WIDTH)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .clear     (do_report),
            .ins_en    (in_acc),
            .ins_value (ins_value),
            .prev_link (link[i]),
            .prev_value(values[i]),
            .link_out  (link[i+1]),
            .value_out (values[i+1])
        );
    end

    // Rank readout mux over the cells.
    assign rank_m1 = rank_reg - RANK_W'(1);

    always_comb begin
        sel_valid = 1'b0;
        sel_value = '0;
        for (int i = 0; i < MAX_K; i++) begin
            if (int'(rank_m1) == i) begin
                sel_valid = link[i+1].valid;
                sel_value = values[i+1];
            end
        end
    end

    assign rank_ok = (rank_reg != '0) && (int'(rank_reg) <= MAX_K) && sel_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rank_reg    <= RANK_RESET;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                rank_reg <= cfg_wr_data;
            end
            if (do_report) begin
                pend_reg    <= 1'b0;
                m_valid_reg <= 1'b1;
            end else begin
                if (in_acc && s_tlast) begin
                    pend_reg <= 1'b1;
                end
                if (m_tready) begin
                    m_valid_reg <= 1'b0;
                end
            end
        end
        if (do_report) begin
            m_value_reg <= rank_ok ? sel_value : '0;
            m_error_reg <= !rank_ok;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = DATA_W'($unsigned(m_value_reg));
    assign m_tuser  = m_error_reg;

endmodule

// ----- sim/tb.sv -----
// Testbench for kth_smallest_select_unit: directed and random sets against a sorted-list predictor.
`timescale 1ns / 100ps

module tb;
    import ksel_pkg::*;

    localparam int MAX_K       = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int DATA_W      = ((VALUE_WIDTH + 7) / 8) * 8;
    localparam int QUIET_LIMIT = 1000;
    localparam int SETTLE_CYC  = 4;
    localparam int NUM_PHASES  = 10;

    localparam logic [RANK_W-1:0] PHASE_RANK [NUM_PHASES] =
        '{5'd1, 5'd16, 5'd7, 5'd0, 5'd12, 5'd31, 5'd16, 5'd2, 5'd17, 5'd9};
    localparam logic [31:0] CORNER [4] =
        '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};

    typedef struct {
        logic [DATA_W-1:0] kth_value;
        logic              rank_error;
    } kth_result_t;

    // Mirrors the insertion chain: keeps the MAX_K smallest values of the open set.
    class rank_scoreboard;
        logic signed [VALUE_WIDTH-1:0] low_values[$];
        logic [RANK_W-1:0]             rank;
        kth_result_t                   pending_kth[$];
        int                            mismatches;

        function new();
            rank       = RANK_RESET;
            mismatches = 0;
        endfunction

        function void set_rank(logic [RANK_W-1:0] r);
            rank = r;
        endfunction

        function int pending();
            return pending_kth.size();
        endfunction

        task report(string what);
            if (mismatches < 50)
                $display("%0t ns: MISMATCH %s", $realtime, what);
            mismatches++;
        endtask

        function void take_sample(logic signed [VALUE_WIDTH-1:0] v, logic last);
            int          pos;
            kth_result_t res;
            pos = 0;
            // equal values go behind existing ones
            while (pos < low_values.size() && !(v < low_values[pos]))
                pos++;
            if (pos < MAX_K) begin
                low_values.insert(pos, v);
                if (low_values.size() > MAX_K)
                    void'(low_values.pop_back());
            end
            if (last) begin
                if (rank >= 1 && rank <= MAX_K && rank <= low_values.size()) begin
                    res.kth_value  = DATA_W'(low_values[rank - 1]);
                    res.rank_error = 1'b0;
                end else begin
                    res.kth_value  = '0;
                    res.rank_error = 1'b1;
                end
                pending_kth.push_back(res);
                low_values.delete();
            end
        endfunction

        task check_result(logic [DATA_W-1:0] got_value, logic got_error);
            kth_result_t want;
            if (pending_kth.size() == 0) begin
                report($sformatf("unexpected word value=%h err=%b", got_value, got_error));
                return;
            end
            want = pending_kth.pop_front();
            if (got_value !== want.kth_value)
                report($sformatf("kth_value got %h want %h", got_value, want.kth_value));
            if (got_error !== want.rank_error)
                report($sformatf("rank_error got %b want %b", got_error, want.rank_error));
        endtask
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [RANK_W-1:0]    cfg_wr_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [DATA_W-1:0]    s_tdata = '0;
    logic                 s_tlast = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [DATA_W-1:0]    m_tdata;
    logic                 m_tuser;

    int                   src_idle_pct = 0;
    int                   snk_stall_pct = 0;
    rank_scoreboard       ksb;

    kth_smallest_select_unit #(
        .MAX_K       (MAX_K),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            ksb.check_result(m_tdata, m_tuser);
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("kth_smallest_select_unit verification failed");
        $finish;
    end

    // tvalid stays high from one word to the next unless the source idles
    task automatic push_word(input logic [DATA_W-1:0] v, input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        ksb.take_sample(v, last);
    endtask

    // stop sending, let every result drain, then give the chain time to go quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (ksb.pending() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    task automatic write_rank(input logic [RANK_W-1:0] r);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= r;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        ksb.set_rank(r);
    endtask

    initial begin
        int                r;
        int                len;
        int                quota;
        int                sent;
        logic [DATA_W-1:0] v;

        ksb = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed sets
        write_rank(5'd1);
        push_word(32'h7FFF_FFFF, 1'b0);
        push_word(32'h8000_0000, 1'b0);
        push_word(32'h0000_0000, 1'b1);
        settle();
        write_rank(5'd3);
        push_word(32'd5, 1'b0);
        push_word(32'd5, 1'b0);
        push_word(32'hFFFF_FFFF, 1'b1);
        push_word(32'd7, 1'b1);                 // fewer words than rank
        settle();
        write_rank(5'd0);
        push_word(32'd1, 1'b1);
        settle();
        write_rank(5'd31);
        push_word(32'd2, 1'b0);
        push_word(32'd3, 1'b1);
        settle();
        write_rank(5'd17);
        push_word(32'hFFFF_FFFB, 1'b1);
        settle();
        write_rank(5'd1);
        push_word(32'd10, 1'b0);
        push_word(32'hFFFF_FFFD, 1'b0);
        settle();
        write_rank(5'd2);                       // rank changed with a set open
        push_word(32'd4, 1'b1);
        push_word(32'h8000_0000, 1'b0);
        push_word(32'h8000_0000, 1'b1);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            settle();
            case (ph % 4)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 85; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 85; end
                default: begin src_idle_pct = 33; snk_stall_pct = 33; end
            endcase
            write_rank(PHASE_RANK[ph]);
            r     = PHASE_RANK[ph];
            quota = (r >= 1 && r <= MAX_K) ? 48 : 10;
            sent  = 0;
            while (sent < quota) begin
                // half the sets sit right around the rank, the rest have 1 to 24 words
                if (r >= 1 && r <= MAX_K && $urandom_range(1))
                    len = $urandom_range((r > 1) ? r - 1 : 1, r + 2);
                else
                    len = $urandom_range(1, 24);
                for (int i = 1; i <= len; i++) begin
                    case ($urandom_range(9))
                        0, 1, 2, 3: v = $urandom;
                        4, 5, 6:    v = $urandom_range(14) - 7;   // dense, many ties
                        7:          v = CORNER[$urandom_range(3)];
                        default:    v = CORNER[$urandom_range(1)] ^ $urandom_range(3);
                    endcase
                    push_word(v, i == len);
                end
                sent += len;
            end
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (ksb.pending() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);

        if (ksb.mismatches == 0)
            $display("kth_smallest_select_unit verification clean");
        else
            $display("kth_smallest_select_unit verification failed");
        $finish;
    end

endmodule
